// ----- rtl/core/ghal_pkg.sv -----
`timescale 1ns / 1ps

package ghal_pkg;

    localparam int MAX_HANDLES = 4096;
    localparam int IDX_W       = 12;
    localparam int GEN_W       = 16;
    localparam int CNT_W       = 32;
    localparam int FRESH_W     = IDX_W + 1;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_CHECK   = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] handle_index;
        logic [GEN_W-1:0] handle_generation;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] out_index;
        logic [GEN_W-1:0] out_generation;
        logic             alive;
        logic [CNT_W-1:0] change_count;
    } rsp_t;

    typedef struct packed {
        logic [GEN_W-1:0] cur_gen;
        logic [GEN_W-1:0] ref_gen;
        logic             skip_zero;
    } gen_op_t;

    typedef struct packed {
        logic [GEN_W-1:0] next_gen;
        logic             match;
    } gen_res_t;

endpackage

// ----- rtl/core/generational_handle_allocator.sv -----
`timescale 1ns / 1ps

// Generation-tagged handle allocator. Each request allocates, releases or
// checks a handle (index plus generation) and yields exactly one response.
// A request is taken only while the block is idle. For release, check, a
// fresh allocate and a full or unused request, the generation memory is read
// at the accepting edge. The compare, increment and write-back through the
// shared generation unit then load the response register in S_EXEC once it
// is free, and the block takes no new request until it is back in idle. An
// allocate that reuses a released index reads the recycle stack first and
// then the generation memory in S_STK. Its response is loaded in S_EXEC, and
// the block stays busy until it is loaded. The response waits in its own
// register, so a stalled consumer holds the block only once the next
// response is ready. The live flag sits beside each generation in one
// memory. Entries at or beyond the next fresh index are never used, so no
// clearing pass follows reset.
module generational_handle_allocator
    import ghal_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STK,
        S_EXEC
    } state_t;

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic               addr_ok_reg, addr_ok_next;
    logic [IDX_W-1:0]   top_reg, top_next;
    logic [FRESH_W-1:0] fresh_reg, fresh_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic               take;
    logic               rsp_free;

    logic               stk_wr_en;
    logic               stk_rd_en;
    logic [IDX_W-1:0]   stk_rd_data;

    logic               gen_wr_en;
    logic [IDX_W-1:0]   gen_wr_addr;
    logic [GEN_W:0]     gen_wr_data;
    logic               gen_rd_en;
    logic [IDX_W-1:0]   gen_rd_addr;
    logic [GEN_W:0]     gen_rd_data;

    gen_op_t            gen_op;
    gen_res_t           gen_res;
    logic               handle_ok;

    assign req_ready = (state_reg == S_IDLE);
    assign take      = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign stk_rd_en   = take && (req.opcode == OP_ALLOC) && (top_reg != '0);
    assign gen_rd_en   = take || (state_reg == S_STK);
    assign gen_rd_addr = (state_reg == S_STK) ? stk_rd_data : req.handle_index;

    ghal_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_HANDLES)
    ) u_stack (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (top_reg),
        .wr_data (req_reg.handle_index),
        .rd_en   (stk_rd_en),
        .rd_addr (top_reg - IDX_W'(1)),
        .rd_data (stk_rd_data)
    );

    ghal_ram #(
        .WIDTH (GEN_W + 1),
        .DEPTH (MAX_HANDLES)
    ) u_gen (
        .clk     (clk),
        .wr_en   (gen_wr_en),
        .wr_addr (gen_wr_addr),
        .wr_data (gen_wr_data),
        .rd_en   (gen_rd_en),
        .rd_addr (gen_rd_addr),
        .rd_data (gen_rd_data)
    );

    assign gen_op.cur_gen   = gen_rd_data[GEN_W-1:0];
    assign gen_op.ref_gen   = req_reg.handle_generation;
    assign gen_op.skip_zero = (req_reg.opcode == OP_ALLOC);

    ghal_gen_unit u_gen_unit (
        .op  (gen_op),
        .res (gen_res)
    );

    assign handle_ok = addr_ok_reg && gen_rd_data[GEN_W] && gen_res.match;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        addr_ok_next   = addr_ok_reg;
        top_next       = top_reg;
        fresh_next     = fresh_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        stk_wr_en      = 1'b0;
        gen_wr_en      = 1'b0;
        gen_wr_addr    = stk_rd_data;
        gen_wr_data    = {1'b1, gen_res.next_gen};

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    req_next     = req;
                    addr_ok_next = (req.handle_index != '0)
                                   && ({1'b0, req.handle_index} < fresh_reg);
                    state_next   = stk_rd_en ? S_STK : S_EXEC;
                end
            end
            S_STK:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (rsp_free)
                begin
                    rsp_next.status         = ST_BAD;
                    rsp_next.out_index      = '0;
                    rsp_next.out_generation = '0;
                    rsp_next.alive          = 1'b0;
                    case (req_reg.opcode)
                        OP_ALLOC:
                        begin
                            if (top_reg != '0)
                            begin
                                gen_wr_en               = 1'b1;
                                top_next                = top_reg - IDX_W'(1);
                                count_next              = count_reg + CNT_W'(1);
                                rsp_next.status         = ST_OK;
                                rsp_next.out_index      = stk_rd_data;
                                rsp_next.out_generation = gen_res.next_gen;
                            end
                            else if (fresh_reg < FRESH_W'(MAX_HANDLES))
                            begin
                                gen_wr_en               = 1'b1;
                                gen_wr_addr             = fresh_reg[IDX_W-1:0];
                                gen_wr_data             = {1'b1, GEN_W'(1)};
                                fresh_next              = fresh_reg + FRESH_W'(1);
                                count_next              = count_reg + CNT_W'(1);
                                rsp_next.status         = ST_OK;
                                rsp_next.out_index      = fresh_reg[IDX_W-1:0];
                                rsp_next.out_generation = GEN_W'(1);
                            end
                            else
                            begin
                                rsp_next.status = ST_FULL;
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (handle_ok)
                            begin
                                stk_wr_en       = 1'b1;
                                gen_wr_en       = 1'b1;
                                gen_wr_addr     = req_reg.handle_index;
                                gen_wr_data     = {1'b0, gen_res.next_gen};
                                top_next        = top_reg + IDX_W'(1);
                                count_next      = count_reg + CNT_W'(1);
                                rsp_next.status = ST_OK;
                            end
                        end
                        OP_CHECK:
                        begin
                            if (handle_ok)
                            begin
                                rsp_next.status = ST_OK;
                                rsp_next.alive  = 1'b1;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = ST_BAD;
                        end
                    endcase
                    rsp_next.change_count = count_next;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            addr_ok_reg   <= 1'b0;
            top_reg       <= '0;
            fresh_reg     <= FRESH_W'(1);
            count_reg     <= CNT_W'(1);
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            addr_ok_reg   <= addr_ok_next;
            top_reg       <= top_next;
            fresh_reg     <= fresh_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

// ----- rtl/core/ghal_ram.sv -----
`timescale 1ns / 1ps

module ghal_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/ghal_gen_unit.sv -----
`timescale 1ns / 1ps

module ghal_gen_unit
    import ghal_pkg::*;
(
    input  gen_op_t  op,
    output gen_res_t res
);

    logic [GEN_W-1:0] inc;

    always_comb
    begin
        inc = op.cur_gen + GEN_W'(1);
        res.match = (op.cur_gen == op.ref_gen);
        // generation zero is skipped when handing out
        if (op.skip_zero && inc == '0)
        begin
            res.next_gen = GEN_W'(1);
        end
        else
        begin
            res.next_gen = inc;
        end
    end

endmodule

// ----- tb/sv/generational_handle_allocator_test.sv -----
`timescale 1ns / 1ps

module generational_handle_allocator_test;

    import ghal_pkg::*;

    localparam int unsigned RUN_LIMIT    = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 750;

    // opcode with no operation behind it
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct {
        req_t        r;
        int unsigned gap;
    } pending_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // handle table as the block should hold it
    logic [IDX_W-1:0]   stack_mem [MAX_HANDLES];
    logic [FRESH_W-1:0] free_top;
    logic [FRESH_W-1:0] fresh_idx;
    logic [GEN_W-1:0]   gen_mem [MAX_HANDLES];
    bit                 live_mem [MAX_HANDLES];
    logic [CNT_W-1:0]   change_cnt;

    pending_req_t req_pending_q[$];
    rsp_t         rsp_expected_q[$];
    rsp_t         rsp_want;
    rsp_t         rsp_next;

    int unsigned idle_left;
    int unsigned stall_left;
    int unsigned rx_roll;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    bit          quiet = 1'b0;
    bit          hold_armed = 1'b0;
    bit          held_once;

    generational_handle_allocator u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic note_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    function automatic req_t make_req(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                                      input logic [GEN_W-1:0] gen);
        req_t r;
        r.opcode = op;
        r.handle_index = idx;
        r.handle_generation = gen;
        return r;
    endfunction

    function automatic bit entry_is_live(input logic [IDX_W-1:0] idx,
                                         input logic [GEN_W-1:0] gen);
        return idx != '0 && {1'b0, idx} < fresh_idx && live_mem[idx] && gen_mem[idx] == gen;
    endfunction

    function automatic rsp_t allocator_step(input req_t r);
        rsp_t             e;
        logic [IDX_W-1:0] n;
        logic [GEN_W-1:0] g;
        bit               got;
        e = '0;
        e.status = ST_BAD;
        got = 1'b0;
        n = '0;
        case (r.opcode)
            OP_ALLOC:
            begin
                if (free_top != '0)
                begin
                    free_top = free_top - FRESH_W'(1);
                    n = stack_mem[free_top[IDX_W-1:0]];
                    g = gen_mem[n] + GEN_W'(1);
                    if (g == '0)
                        g = GEN_W'(1);
                    gen_mem[n] = g;
                    got = 1'b1;
                end
                else if (fresh_idx < FRESH_W'(MAX_HANDLES))
                begin
                    n = fresh_idx[IDX_W-1:0];
                    fresh_idx = fresh_idx + FRESH_W'(1);
                    gen_mem[n] = GEN_W'(1);
                    got = 1'b1;
                end
                if (got)
                begin
                    live_mem[n] = 1'b1;
                    change_cnt = change_cnt + CNT_W'(1);
                    e.status = ST_OK;
                    e.out_index = n;
                    e.out_generation = gen_mem[n];
                end
                else
                    e.status = ST_FULL;
            end
            OP_RELEASE:
            begin
                if (entry_is_live(r.handle_index, r.handle_generation)
                    && free_top < FRESH_W'(MAX_HANDLES))
                begin
                    stack_mem[free_top[IDX_W-1:0]] = r.handle_index;
                    free_top = free_top + FRESH_W'(1);
                    gen_mem[r.handle_index] = gen_mem[r.handle_index] + GEN_W'(1);
                    live_mem[r.handle_index] = 1'b0;
                    change_cnt = change_cnt + CNT_W'(1);
                    e.status = ST_OK;
                end
            end
            OP_CHECK:
            begin
                if (entry_is_live(r.handle_index, r.handle_generation))
                begin
                    e.alive = 1'b1;
                    e.status = ST_OK;
                end
            end
            default:
                e.status = ST_BAD;
        endcase
        e.change_count = change_cnt;
        return e;
    endfunction

    // mostly well-formed requests on live handles, some stale, some noise
    function automatic req_t random_request();
        req_t             r;
        int unsigned      roll;
        int unsigned      tries;
        logic [IDX_W-1:0] pick;
        r = make_req(OP_ALLOC, IDX_W'($urandom), GEN_W'($urandom));
        roll = $urandom_range(0, 99);
        if (roll >= 40 && roll < 92 && fresh_idx > FRESH_W'(1))
        begin
            pick = IDX_W'($urandom_range(1, int'(fresh_idx) - 1));
            for (tries = 0; tries < 16 && !live_mem[pick]; tries++)
                pick = IDX_W'($urandom_range(1, int'(fresh_idx) - 1));
            r.opcode = (roll < 70) ? OP_RELEASE : OP_CHECK;
            r.handle_index = pick;
            r.handle_generation = gen_mem[pick];
            if (roll % 6 == 0)
                r.handle_generation = gen_mem[pick] - GEN_W'(1);
        end
        else if (roll >= 40)
        begin
            r.opcode = 2'($urandom_range(0, 3));
            if (roll % 3 == 0)
                r.handle_index = '0;
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 96)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    task automatic queue_request(input req_t r);
        pending_req_t p;
        p.r = r;
        p.gap = pick_gap();
        req_pending_q.push_back(p);
    endtask

    task automatic wait_requests_taken();
        @(negedge clk);
        while (req_pending_q.size() != 0 || req_valid)
            @(negedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            idle_left <= 0;
        end
        else if (!req_valid || req_ready)
        begin
            if (idle_left != 0)
            begin
                req_valid <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (req_pending_q.size() != 0)
            begin
                req_valid <= 1'b1;
                req <= req_pending_q[0].r;
                idle_left <= req_pending_q[0].gap;
                void'(req_pending_q.pop_front());
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response consumer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_left <= 0;
            held_once <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (hold_armed && !held_once)
        begin
            held_once <= 1'b1;
            rsp_ready <= 1'b0;
            stall_left <= 300;
        end
        else if (quiet)
            rsp_ready <= 1'b1;
        else
        begin
            rx_roll = $urandom_range(0, 999);
            if (rx_roll < 2)
            begin
                rsp_ready <= 1'b0;
                stall_left <= $urandom_range(30, 120);
            end
            else
                rsp_ready <= (rx_roll >= 300);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                rsp_next = allocator_step(req);
                rsp_expected_q.push_back(rsp_next);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_expected_q.size() == 0)
                    note_mismatch($sformatf("response with nothing outstanding: %h", rsp));
                else
                begin
                    rsp_want = rsp_expected_q.pop_front();
                    if (rsp.status !== rsp_want.status)
                        note_mismatch($sformatf("status got %0d want %0d",
                                                rsp.status, rsp_want.status));
                    if (rsp.out_index !== rsp_want.out_index)
                        note_mismatch($sformatf("out_index got %0d want %0d",
                                                rsp.out_index, rsp_want.out_index));
                    if (rsp.out_generation !== rsp_want.out_generation)
                        note_mismatch($sformatf("out_generation got %0d want %0d",
                                                rsp.out_generation, rsp_want.out_generation));
                    if (rsp.alive !== rsp_want.alive)
                        note_mismatch($sformatf("alive got %0d want %0d",
                                                rsp.alive, rsp_want.alive));
                    if (rsp.change_count !== rsp_want.change_count)
                        note_mismatch($sformatf("change_count got %0d want %0d",
                                                rsp.change_count, rsp_want.change_count));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("generational_handle_allocator regression: fail");
            $finish;
        end
    end

    initial
    begin
        int unsigned i;
        int unsigned batch;
        int unsigned issued;

        for (i = 0; i < MAX_HANDLES; i++)
        begin
            stack_mem[i] = '0;
            gen_mem[i] = '0;
            live_mem[i] = 1'b0;
        end
        free_top = '0;
        fresh_idx = FRESH_W'(1);
        change_cnt = CNT_W'(1);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: index zero, out of range, unused opcode, stale and dead handles, lifo reuse
        queue_request(make_req(OP_CHECK, '0, '0));
        queue_request(make_req(OP_RELEASE, '0, '0));
        queue_request(make_req(OP_CHECK, '1, '1));
        queue_request(make_req(OP_SPARE, '1, '1));
        queue_request(make_req(OP_ALLOC, '1, '1));
        queue_request(make_req(OP_ALLOC, '0, '0));
        queue_request(make_req(OP_CHECK, IDX_W'(1), GEN_W'(1)));
        queue_request(make_req(OP_CHECK, IDX_W'(1), GEN_W'(2)));
        queue_request(make_req(OP_RELEASE, IDX_W'(2), GEN_W'(0)));
        queue_request(make_req(OP_RELEASE, IDX_W'(2), GEN_W'(1)));
        queue_request(make_req(OP_RELEASE, IDX_W'(2), GEN_W'(1)));
        queue_request(make_req(OP_CHECK, IDX_W'(2), GEN_W'(1)));
        queue_request(make_req(OP_CHECK, IDX_W'(2), GEN_W'(2)));
        queue_request(make_req(OP_ALLOC, '0, '0));
        queue_request(make_req(OP_RELEASE, IDX_W'(1), GEN_W'(1)));
        queue_request(make_req(OP_RELEASE, IDX_W'(2), GEN_W'(3)));
        queue_request(make_req(OP_ALLOC, '0, '0));
        queue_request(make_req(OP_ALLOC, '0, '0));
        queue_request(make_req(OP_ALLOC, '0, '0));
        queue_request(make_req(OP_CHECK, IDX_W'(3), '1));
        queue_request(make_req(OP_RELEASE, '1, '0));
        queue_request(make_req(OP_SPARE, '0, '0));
        wait_requests_taken();

        // random mix in short bursts
        hold_armed = 1'b1;
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            batch = $urandom_range(1, 12);
            quiet = ($urandom_range(0, 9) == 0);
            repeat (batch) queue_request(random_request());
            issued += batch;
            wait_requests_taken();
        end
        quiet = 1'b0;

        while (rsp_expected_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (mismatches == 0)
            $display("generational_handle_allocator regression: pass");
        else
            $display("generational_handle_allocator regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/ghal_pkg.sv
rtl/core/ghal_ram.sv
rtl/core/ghal_gen_unit.sv
rtl/core/generational_handle_allocator.sv
tb/sv/generational_handle_allocator_test.sv
